FILE: src/iol_pkg.sv
// iol_pkg: shared types and constants for the indexed ordered list core
// holds command, status and cell-op codes plus the request payload structs
// no dependencies
package iol_pkg;

  localparam int CapacityDef = 16;
  localparam int DataW       = 32;
  localparam int LenW        = 5;
  localparam int InPosW      = 5;

  typedef enum logic [2:0] {
    CMD_INS_FRONT = 3'd0,
    CMD_INS_POS   = 3'd1,
    CMD_INS_END   = 3'd2,
    CMD_DEL_FRONT = 3'd3,
    CMD_DEL_POS   = 3'd4,
    CMD_DEL_END   = 3'd5,
    CMD_DUMP      = 3'd6
  } iol_cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } iol_status_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INS,
    CELL_DEL,
    CELL_ROT
  } iol_cell_op_t;

  typedef enum logic {
    S_IDLE,
    S_DUMP
  } iol_state_t;

  typedef struct packed {
    logic [2:0]              cmd;
    logic signed [DataW-1:0] value;
    logic [InPosW-1:0]       position;
  } iol_in_req_t;

  typedef struct packed {
    logic [1:0]              status;
    logic signed [DataW-1:0] item_value;
    logic [LenW-1:0]         list_length;
    logic                    last;
  } iol_out_req_t;

endpackage

FILE: src/iol_cell.sv
// iol_cell: one storage cell of the list chain
// shifts in from its left or right neighbor, takes a new value, or holds
// depends on iol_pkg
module iol_cell #(
  parameter int PosW  = 5,
  parameter int Index = 0
) (
  input  logic                            clk,
  input  iol_pkg::iol_cell_op_t           op_i,
  input  logic [PosW-1:0]                 pos_i,
  input  logic signed [iol_pkg::DataW-1:0] new_i,
  input  logic signed [iol_pkg::DataW-1:0] left_i,
  input  logic signed [iol_pkg::DataW-1:0] right_i,
  input  logic signed [iol_pkg::DataW-1:0] head_i,
  output logic signed [iol_pkg::DataW-1:0] val_o
);

  localparam logic [PosW-1:0] MyIdx   = PosW'(Index);
  localparam logic [PosW-1:0] NextIdx = PosW'(Index + 1);

  logic signed [iol_pkg::DataW-1:0] val_r;
  logic signed [iol_pkg::DataW-1:0] val_nxt;

  always_comb begin
    val_nxt = val_r;
    case (op_i)
      iol_pkg::CELL_INS: begin
        if (MyIdx > pos_i) begin
          val_nxt = left_i;
        end else if (MyIdx == pos_i) begin
          val_nxt = new_i;
        end
      end
      iol_pkg::CELL_DEL: begin
        if (MyIdx >= pos_i) begin
          val_nxt = right_i;
        end
      end
      iol_pkg::CELL_ROT: begin
        // the cell at the tail of the used region wraps the head around
        if (NextIdx == pos_i) begin
          val_nxt = head_i;
        end else begin
          val_nxt = right_i;
        end
      end
      default: begin
        val_nxt = val_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val_o = val_r;

endmodule

FILE: src/iol_out_buf.sv
// iol_out_buf: two-entry result queue in front of the out channel
// lets the core finish a request while an earlier result waits
// depends on iol_pkg
module iol_out_buf (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push_i,
  input  iol_pkg::iol_out_req_t data_i,
  output logic                  full_o,
  output logic                  out_valid,
  input  logic                  out_stall,
  output iol_pkg::iol_out_req_t out_req
);

  logic [1:0]            cnt_r;
  logic [1:0]            cnt_nxt;
  iol_pkg::iol_out_req_t q0_r;
  iol_pkg::iol_out_req_t q0_nxt;
  iol_pkg::iol_out_req_t q1_r;
  iol_pkg::iol_out_req_t q1_nxt;
  logic                  pop;
  logic                  wr_lo;

  assign out_valid = (cnt_r != 2'd0);
  assign out_req   = q0_r;
  assign full_o    = (cnt_r == 2'd2);
  assign pop       = out_valid && !out_stall;

  always_comb begin
    cnt_nxt = cnt_r + 2'(push_i) - 2'(pop);
    q0_nxt  = q0_r;
    q1_nxt  = q1_r;
    wr_lo   = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && pop);
    if (pop) begin
      q0_nxt = q1_r;
    end
    if (push_i) begin
      if (wr_lo) begin
        q0_nxt = data_i;
      end else begin
        q1_nxt = data_i;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q0_r <= q0_nxt;
    q1_r <= q1_nxt;
  end

endmodule

FILE: src/indexed_ordered_list_core.sv
// indexed_ordered_list_core: ordered list of signed values in a chain of shifting cells
// insert/delete/other: result via the result queue; one request per cycle while a slot is free
// dump: elements leave through the dump state and the result queue, one per cycle while a queue
//   slot is free; input held off while the chain rotates once through the used cells
// reset (rst_n low, synchronous) empties the list and the result queue; cell data is not cleared
// depends on iol_pkg, iol_cell, iol_out_buf
module indexed_ordered_list_core #(
  parameter int CAPACITY = iol_pkg::CapacityDef
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  iol_pkg::iol_in_req_t  in_req,
  output logic                  out_valid,
  input  logic                  out_stall,
  output iol_pkg::iol_out_req_t out_req
);

  // count must hold CAPACITY itself; positions compare at the wider of count and port width
  localparam int CntW = $clog2(CAPACITY + 1);
  localparam int PosW = (CntW > iol_pkg::InPosW) ? CntW : iol_pkg::InPosW;

  // list state
  logic [CntW-1:0]        count_r;
  logic [CntW-1:0]        count_nxt;
  iol_pkg::iol_state_t    state_r;
  iol_pkg::iol_state_t    state_nxt;
  logic [PosW-1:0]        dump_idx_r;
  logic [PosW-1:0]        dump_idx_nxt;

  // cell chain control and data
  iol_pkg::iol_cell_op_t            cell_op;
  logic [PosW-1:0]                  cell_pos;
  logic signed [iol_pkg::DataW-1:0] cell_val   [CAPACITY];
  logic signed [iol_pkg::DataW-1:0] cell_left  [CAPACITY];
  logic signed [iol_pkg::DataW-1:0] cell_right [CAPACITY];

  // request decode
  logic                  accept;
  logic [PosW-1:0]       count_x;
  logic [PosW-1:0]       pos_x;
  logic [PosW-1:0]       cap_x;
  logic [PosW-1:0]       tgt_pos;
  logic                  dump_last;

  // result queue side
  logic                  push;
  iol_pkg::iol_out_req_t push_data;
  logic                  buf_full;

  // only idle, and only with a free queue slot, so every accepted request can post its result
  assign in_stall = (state_r != iol_pkg::S_IDLE) || buf_full;
  assign accept   = in_valid && !in_stall;

  assign count_x   = PosW'(count_r);
  assign pos_x     = PosW'(in_req.position);
  assign cap_x     = PosW'(CAPACITY);
  assign dump_last = (dump_idx_r == (count_x - PosW'(1)));

  // target position for the positional forms
  always_comb begin
    case (iol_pkg::iol_cmd_t'(in_req.cmd))
      iol_pkg::CMD_INS_POS,
      iol_pkg::CMD_DEL_POS: tgt_pos = pos_x;
      iol_pkg::CMD_INS_END: tgt_pos = count_x;
      iol_pkg::CMD_DEL_END: tgt_pos = count_x - PosW'(1);
      default:              tgt_pos = '0;
    endcase
  end

  // sequencer: decodes requests, drives the cell chain and builds results
  always_comb begin
    state_nxt              = state_r;
    dump_idx_nxt           = dump_idx_r;
    count_nxt              = count_r;
    cell_op                = iol_pkg::CELL_HOLD;
    cell_pos               = '0;
    push                   = 1'b0;
    push_data.status       = iol_pkg::ST_OK;
    push_data.item_value   = '0;
    push_data.last         = 1'b1;

    case (state_r)
      iol_pkg::S_IDLE: begin
        if (accept) begin
          push = 1'b1;
          case (iol_pkg::iol_cmd_t'(in_req.cmd))
            iol_pkg::CMD_INS_FRONT,
            iol_pkg::CMD_INS_POS,
            iol_pkg::CMD_INS_END: begin
              // full is reported ahead of a bad position
              if (count_x == cap_x) begin
                push_data.status = iol_pkg::ST_FULL;
              end else if (tgt_pos > count_x) begin
                push_data.status = iol_pkg::ST_RANGE;
              end else begin
                cell_op   = iol_pkg::CELL_INS;
                cell_pos  = tgt_pos;
                count_nxt = count_r + CntW'(1);
              end
            end
            iol_pkg::CMD_DEL_FRONT,
            iol_pkg::CMD_DEL_POS,
            iol_pkg::CMD_DEL_END: begin
              // empty is reported ahead of a bad position
              if (count_r == '0) begin
                push_data.status = iol_pkg::ST_EMPTY;
              end else if (tgt_pos >= count_x) begin
                push_data.status = iol_pkg::ST_RANGE;
              end else begin
                cell_op   = iol_pkg::CELL_DEL;
                cell_pos  = tgt_pos;
                count_nxt = count_r - CntW'(1);
              end
            end
            iol_pkg::CMD_DUMP: begin
              if (count_r == '0) begin
                push_data.status = iol_pkg::ST_EMPTY;
              end else begin
                // elements come out of the dump state, one per free queue slot
                push         = 1'b0;
                state_nxt    = iol_pkg::S_DUMP;
                dump_idx_nxt = '0;
              end
            end
            default: begin
              // unused code: plain ok, list untouched
              push_data.status = iol_pkg::ST_OK;
            end
          endcase
        end
      end
      iol_pkg::S_DUMP: begin
        if (!buf_full) begin
          // emit the head, then rotate the used cells left by one
          push                 = 1'b1;
          push_data.item_value = cell_val[0];
          push_data.last       = dump_last;
          cell_op              = iol_pkg::CELL_ROT;
          cell_pos             = count_x;
          dump_idx_nxt         = dump_idx_r + PosW'(1);
          if (dump_last) begin
            state_nxt = iol_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = iol_pkg::S_IDLE;
      end
    endcase

    // length after the request, truncated or widened to the port width
    push_data.list_length = iol_pkg::LenW'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= iol_pkg::S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dump_idx_r <= dump_idx_nxt;
  end

  // chain of cells, cell 0 is the front of the list
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign cell_left[i] = in_req.value;
    end else begin : g_mid_l
      assign cell_left[i] = cell_val[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign cell_right[i] = cell_val[i];
    end else begin : g_mid_r
      assign cell_right[i] = cell_val[i+1];
    end

    iol_cell #(
      .PosW  (PosW),
      .Index (i)
    ) u_cell (
      .clk     (clk),
      .op_i    (cell_op),
      .pos_i   (cell_pos),
      .new_i   (in_req.value),
      .left_i  (cell_left[i]),
      .right_i (cell_right[i]),
      .head_i  (cell_val[0]),
      .val_o   (cell_val[i])
    );
  end

  // result queue toward the out channel
  iol_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_i    (push),
    .data_i    (push_data),
    .full_o    (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_req   (out_req)
  );

`ifndef SYNTHESIS
  // the element count never runs past the number of cells
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_x <= cap_x)
    else $error("element count above capacity");

  // a dump leaves the list length unchanged
  a_dump_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == iol_pkg::S_DUMP) |=> (count_r == $past(count_r)))
    else $error("count changed during dump");

  // the final dump element returns the sequencer to idle
  a_dump_end: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == iol_pkg::S_DUMP) && push && dump_last) |=> (state_r == iol_pkg::S_IDLE))
    else $error("dump did not end after last element");

  // no result is posted into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !buf_full)
    else $error("result pushed into full queue");
`endif

endmodule
